/* rtl/gbsp_pkg.sv */
// Shared types, codes and constants of the grid breadth-first path finder.
`default_nettype none

package gbsp_pkg;

   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 256;

   localparam int DIST_W  = 16;
   localparam int EPOCH_W = 8;
   localparam int DIM_W   = 9;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // item kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_BLOCK = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // register index, taken from the word-address bit of paddr
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cell_row;
      logic [7:0] cell_col;
      logic [7:0] dest_row;
      logic [7:0] dest_col;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              reachable;
   } rsp_type;

   // one word of the cell memory: obstacle bit, visit epoch, step count
   typedef struct packed {
      logic               blk;
      logic [EPOCH_W-1:0] tag;
      logic [DIST_W-1:0]  steps;
   } cell_type;

   typedef struct packed {
      logic    go;
      req_type item;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage

`default_nettype wire

/* rtl/gbsp_engine.sv */
// Flood engine: cell memory, cell queue memory and the sequencer that walks them.
`default_nettype none

module gbsp_engine #(
   parameter int MAX_ROWS = gbsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gbsp_pkg::DEF_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gbsp_pkg::cmd_type                cmd,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    rows_lim,
   input  logic [$clog2(MAX_COLS+1)-1:0]    cols_lim,
   output logic                             busy,
   output gbsp_pkg::res_type                res,
   input  logic                             res_ready
);
   import gbsp_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RDW   = $clog2(MAX_ROWS+1);
   localparam int CDW   = $clog2(MAX_COLS+1);
   localparam int IW    = RW + CW;
   localparam int DEPTH = 2 ** IW;
   localparam int PW    = IW + 1;

   localparam logic [2:0] NBR_COUNT = 3'd4;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SWEEP    = 4'd1;
   localparam logic [3:0] S_START_RD = 4'd2;
   localparam logic [3:0] S_START_WR = 4'd3;
   localparam logic [3:0] S_POP      = 4'd4;
   localparam logic [3:0] S_LOAD     = 4'd5;
   localparam logic [3:0] S_NBR      = 4'd6;
   localparam logic [3:0] S_DEST_RD  = 4'd7;
   localparam logic [3:0] S_DEST_CHK = 4'd8;
   localparam logic [3:0] S_RESULT   = 4'd9;

   typedef struct packed {
      logic [IW-1:0]     addr;
      logic [DIST_W-1:0] steps;
   } qent_type;

   cell_type cell_mem  [DEPTH];
   qent_type queue_mem [DEPTH];

   logic [3:0]         state_ff, state_in;
   logic [PW-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic               swp_v_ff, swp_v_in;
   logic [IW-1:0]      swp_addr_ff, swp_addr_in;
   logic               keep_ff, keep_in;
   logic               then_query_ff, then_query_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IW-1:0]      start_addr_ff, start_addr_in;
   logic [IW-1:0]      dest_addr_ff, dest_addr_in;
   logic               dest_ok_ff, dest_ok_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic [RW-1:0]      cur_r_ff, cur_r_in;
   logic [CW-1:0]      cur_c_ff, cur_c_in;
   logic [DIST_W-1:0]  cur_d_ff, cur_d_in;
   logic [2:0]         j_ff, j_in;
   logic               nb_v_ff, nb_v_in;
   logic [IW-1:0]      nb_addr_ff, nb_addr_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic               res_reach_ff, res_reach_in;

   cell_type           cm_rdata_ff;
   qent_type           q_rdata_ff;

   logic               cm_we;
   logic [IW-1:0]      cm_waddr, cm_raddr;
   cell_type           cm_wdata;
   logic               q_we;
   logic [IW-1:0]      q_waddr, q_raddr;
   qent_type           q_wdata;

   logic               blk_ok, start_ok, dest_ok;
   logic [IW-1:0]      item_addr, item_dest_addr;
   logic               nb_ok;
   logic [RW-1:0]      nb_r;
   logic [CW-1:0]      nb_c;
   logic [DIST_W-1:0]  nd;
   logic               fresh;

   // memories: one write and one registered read a cycle each
   always_ff @(posedge clock) begin
      if (cm_we) begin
         cell_mem[cm_waddr] <= cm_wdata;
      end
      cm_rdata_ff <= cell_mem[cm_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      q_rdata_ff <= queue_mem[q_raddr];
   end

   // item decode
   always_comb begin
      blk_ok   = (32'(cmd.item.cell_row) < MAX_ROWS) && (32'(cmd.item.cell_col) < MAX_COLS);
      start_ok = (32'(cmd.item.cell_row) < 32'(rows_lim)) &&
                 (32'(cmd.item.cell_col) < 32'(cols_lim));
      dest_ok  = (32'(cmd.item.dest_row) < 32'(rows_lim)) &&
                 (32'(cmd.item.dest_col) < 32'(cols_lim));
      item_addr      = {RW'(cmd.item.cell_row), CW'(cmd.item.cell_col)};
      item_dest_addr = {RW'(cmd.item.dest_row), CW'(cmd.item.dest_col)};
   end

   // neighbour j of the current cell: up, left, right, down
   always_comb begin
      nb_ok = 1'b0;
      nb_r  = cur_r_ff;
      nb_c  = cur_c_ff;
      case (j_ff)
         3'd0: begin
            nb_ok = (cur_r_ff != '0);
            nb_r  = cur_r_ff - RW'(1);
         end
         3'd1: begin
            nb_ok = (cur_c_ff != '0);
            nb_c  = cur_c_ff - CW'(1);
         end
         3'd2: begin
            nb_ok = (CDW'(cur_c_ff) + CDW'(1)) < cols_lim;
            nb_c  = cur_c_ff + CW'(1);
         end
         3'd3: begin
            nb_ok = (RDW'(cur_r_ff) + RDW'(1)) < rows_lim;
            nb_r  = cur_r_ff + RW'(1);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   assign nd    = (cur_d_ff == '1) ? '1 : cur_d_ff + DIST_W'(1);
   assign fresh = nb_v_ff && !cm_rdata_ff.blk && (cm_rdata_ff.tag != epoch_ff);

   always_comb begin
      state_in      = state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      swp_v_in      = 1'b0;
      swp_addr_in   = swp_addr_ff;
      keep_in       = keep_ff;
      then_query_in = then_query_ff;
      epoch_in      = epoch_ff;
      start_addr_in = start_addr_ff;
      dest_addr_in  = dest_addr_ff;
      dest_ok_in    = dest_ok_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_r_in      = cur_r_ff;
      cur_c_in      = cur_c_ff;
      cur_d_in      = cur_d_ff;
      j_in          = j_ff;
      nb_v_in       = 1'b0;
      nb_addr_in    = nb_addr_ff;
      res_dist_in   = res_dist_ff;
      res_reach_in  = res_reach_ff;

      cm_we    = 1'b0;
      cm_waddr = '0;
      cm_wdata = '0;
      cm_raddr = '0;
      q_we     = 1'b0;
      q_waddr  = '0;
      q_wdata  = '0;
      q_raddr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.go) begin
               unique case (cmd.item.kind)
                  KIND_CLEAR: begin
                     state_in      = S_SWEEP;
                     sweep_cnt_in  = '0;
                     keep_in       = 1'b0;
                     then_query_in = 1'b0;
                  end
                  KIND_BLOCK: begin
                     // a blocked cell never counts as visited, so its tag may drop
                     if (blk_ok) begin
                        cm_we    = 1'b1;
                        cm_waddr = item_addr;
                        cm_wdata = '{blk: 1'b1, tag: '0, steps: '0};
                     end
                  end
                  KIND_QUERY: begin
                     start_addr_in = item_addr;
                     dest_addr_in  = item_dest_addr;
                     dest_ok_in    = dest_ok;
                     if (!start_ok) begin
                        res_dist_in  = '0;
                        res_reach_in = 1'b0;
                        state_in     = S_RESULT;
                     end else if (epoch_ff == '1) begin
                        // epoch runs out: wipe all tags, keep obstacles
                        epoch_in      = EPOCH_W'(1);
                        state_in      = S_SWEEP;
                        sweep_cnt_in  = '0;
                        keep_in       = 1'b1;
                        then_query_in = 1'b1;
                     end else begin
                        epoch_in = epoch_ff + EPOCH_W'(1);
                        state_in = S_START_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SWEEP: begin
            if (sweep_cnt_ff != PW'(DEPTH)) begin
               cm_raddr     = sweep_cnt_ff[IW-1:0];
               swp_v_in     = 1'b1;
               swp_addr_in  = sweep_cnt_ff[IW-1:0];
               sweep_cnt_in = sweep_cnt_ff + PW'(1);
            end
            if (swp_v_ff) begin
               cm_we    = 1'b1;
               cm_waddr = swp_addr_ff;
               cm_wdata = '{blk: keep_ff & cm_rdata_ff.blk, tag: '0, steps: '0};
            end
            if (sweep_cnt_ff == PW'(DEPTH) && !swp_v_ff) begin
               state_in = then_query_ff ? S_START_RD : S_IDLE;
            end
         end

         S_START_RD: begin
            cm_raddr = start_addr_ff;
            state_in = S_START_WR;
         end

         S_START_WR: begin
            cm_we    = 1'b1;
            cm_waddr = start_addr_ff;
            cm_wdata = '{blk: cm_rdata_ff.blk, tag: epoch_ff, steps: '0};
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = '{addr: start_addr_ff, steps: '0};
            head_in  = '0;
            tail_in  = PW'(1);
            state_in = S_POP;
         end

         S_POP: begin
            q_raddr  = head_ff[IW-1:0];
            head_in  = head_ff + PW'(1);
            state_in = S_LOAD;
         end

         S_LOAD: begin
            cur_r_in = q_rdata_ff.addr[IW-1:CW];
            cur_c_in = q_rdata_ff.addr[CW-1:0];
            cur_d_in = q_rdata_ff.steps;
            j_in     = '0;
            state_in = S_NBR;
         end

         S_NBR: begin
            // check the neighbour read last cycle
            if (fresh) begin
               cm_we    = 1'b1;
               cm_waddr = nb_addr_ff;
               cm_wdata = '{blk: 1'b0, tag: epoch_ff, steps: nd};
               q_we     = 1'b1;
               q_waddr  = tail_ff[IW-1:0];
               q_wdata  = '{addr: nb_addr_ff, steps: nd};
               tail_in  = tail_ff + PW'(1);
            end
            // issue the next neighbour read
            if (j_ff != NBR_COUNT) begin
               cm_raddr   = {nb_r, nb_c};
               nb_v_in    = nb_ok;
               nb_addr_in = {nb_r, nb_c};
               j_in       = j_ff + 3'd1;
            end else begin
               state_in = (head_ff != tail_in) ? S_POP : S_DEST_RD;
            end
         end

         S_DEST_RD: begin
            cm_raddr = dest_addr_ff;
            state_in = S_DEST_CHK;
         end

         S_DEST_CHK: begin
            res_reach_in = dest_ok_ff && (cm_rdata_ff.tag == epoch_ff);
            res_dist_in  = res_reach_in ? cm_rdata_ff.steps : '0;
            state_in     = S_RESULT;
         end

         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // clearing pass over the cell memory after reset
         state_ff      <= S_SWEEP;
         sweep_cnt_ff  <= '0;
         swp_v_ff      <= 1'b0;
         keep_ff       <= 1'b0;
         then_query_ff <= 1'b0;
         epoch_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         j_ff          <= '0;
         nb_v_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         swp_v_ff      <= swp_v_in;
         keep_ff       <= keep_in;
         then_query_ff <= then_query_in;
         epoch_ff      <= epoch_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         j_ff          <= j_in;
         nb_v_ff       <= nb_v_in;
      end
   end

   always_ff @(posedge clock) begin
      swp_addr_ff   <= swp_addr_in;
      start_addr_ff <= start_addr_in;
      dest_addr_ff  <= dest_addr_in;
      dest_ok_ff    <= dest_ok_in;
      cur_r_ff      <= cur_r_in;
      cur_c_ff      <= cur_c_in;
      cur_d_ff      <= cur_d_in;
      nb_addr_ff    <= nb_addr_in;
      res_dist_ff   <= res_dist_in;
      res_reach_ff  <= res_reach_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      res.valid          = (state_ff == S_RESULT);
      res.data.distance  = res_dist_ff;
      res.data.reachable = res_reach_ff;
   end

endmodule

`default_nettype wire

/* rtl/grid_bfs_shortest_path.sv */
// Top level of the grid breadth-first path finder: registers, output stage, flood engine.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  gbsp_pkg::req_type (kind, cell, destination)
//   rsp_      out         rsp_valid / rsp_stall  gbsp_pkg::rsp_type (distance, reachable)
//   csr_      in/out      APB psel/penable/ready grid_rows at 0x0, grid_cols at 0x4
//
// Work: a block item leaves the engine idle, and such items may follow back to back.
// A clear item makes a read and write-back pass over the cell memory, one entry a
// cycle through its single write port. A query with the start outside the grid goes
// straight to its result; otherwise the engine takes a queue read, a load, four
// neighbour reads and a last check for each reached cell.
// Every 255th flooding query first wipes the visit epochs in a pass that keeps obstacles.
// Reset: a clearing pass follows reset; req_stall stays high.
// Stalls: req_stall is high while the engine works; a finished result waits in the
// output register, and the engine holds its next result until that register frees.
`default_nettype none

module grid_bfs_shortest_path #(
   parameter int MAX_ROWS = gbsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gbsp_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  gbsp_pkg::req_type             req_data,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gbsp_pkg::rsp_type             rsp_data,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gbsp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [gbsp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [gbsp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import gbsp_pkg::*;

   localparam int RDW = $clog2(MAX_ROWS+1);
   localparam int CDW = $clog2(MAX_COLS+1);

   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [RDW-1:0]   rows_lim;
   logic [CDW-1:0]   cols_lim;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cmd_type          eng_cmd;
   res_type          eng_res;
   logic             eng_busy;
   logic             res_ready;
   logic             res_load;

   // configuration registers; write them only while the block is idle, since the
   // flood reads the clamped sizes throughout a query
   assign csr_pready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[CSR_AW-1])
            REG_ROWS: rows_in = csr_pwdata[DIM_W-1:0];
            REG_COLS: cols_in = csr_pwdata[DIM_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_AW-1])
         REG_ROWS: csr_prdata = CSR_DW'(rows_ff);
         REG_COLS: csr_prdata = CSR_DW'(cols_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // clamp the grid size: zero acts as one, anything past storage as the maximum
   always_comb begin
      if (rows_ff == '0) begin
         rows_lim = RDW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_lim = RDW'(MAX_ROWS);
      end else begin
         rows_lim = RDW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_lim = CDW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_lim = CDW'(MAX_COLS);
      end else begin
         cols_lim = CDW'(cols_ff);
      end
   end

   // input side: a transaction goes straight to the engine when it is idle
   assign req_stall   = eng_busy;
   assign eng_cmd.go  = req_valid && !req_stall;
   assign eng_cmd.item = req_data;

   gbsp_engine #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (eng_cmd),
      .rows_lim  (rows_lim),
      .cols_lim  (cols_lim),
      .busy      (eng_busy),
      .res       (eng_res),
      .res_ready (res_ready)
   );

   // output register: frees when empty or when its transaction is taken this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign res_load  = eng_res.valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_res.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_RESET;
         cols_ff      <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/gbsp_checker.sv */
// Port-level checks of the grid path finder and their binding to the top level.
`default_nettype none

module gbsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input gbsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gbsp_pkg::rsp_type rsp_data
);
   import gbsp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an unreachable destination reports distance zero
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reachable |-> rsp_data.distance == '0)
      else $error("unreachable result with non-zero distance");

   // marking a cell blocked leaves the block ready for the next transaction
   a_block_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == KIND_BLOCK |=> !req_stall)
      else $error("stall after a block transaction");

   // a query or a clear always occupies the engine
   a_work_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.kind == KIND_QUERY || req_data.kind == KIND_CLEAR) |=> req_stall)
      else $error("no stall after a query or clear transaction");

endmodule

bind grid_bfs_shortest_path gbsp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/grid_path_checker.sv */
// Path checker: watches the item, result and register channels and checks every result.
module grid_path_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  gbsp_pkg::req_type                  req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  gbsp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gbsp_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [gbsp_pkg::CSR_DW-1:0]        csr_pwdata,
   input  logic                               csr_pready,
   output int                                 mismatches,
   output int                                 outstanding
);
   import gbsp_pkg::*;

   localparam int GRID_COLS = DEF_MAX_COLS;
   localparam int NCELLS    = DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam int REG_BIT   = 2;
   localparam int REPORT_MAX = 10;

   bit               obstacle [NCELLS];
   bit               reached  [NCELLS];
   logic [DIST_W-1:0] steps   [NCELLS];
   int unsigned      frontier [$];
   rsp_type          expected_paths [$];
   logic [DIM_W-1:0] rows_setting;
   logic [DIM_W-1:0] cols_setting;
   int               errors = 0;
   int               result_count = 0;

   function automatic int usable_dim(input logic [DIM_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   // Flood from the start cell and report the destination's step count.
   function automatic rsp_type flood_distance(input req_type it);
      int rows_n, cols_n, r, c, nr, nc, j;
      int unsigned cur, idx;
      logic [DIST_W-1:0] nd;
      rsp_type res;
      res = '0;
      rows_n = usable_dim(rows_setting, DEF_MAX_ROWS);
      cols_n = usable_dim(cols_setting, DEF_MAX_COLS);
      if (it.cell_row < rows_n && it.cell_col < cols_n) begin
         for (r = 0; r < rows_n; r++)
            for (c = 0; c < cols_n; c++)
               reached[r * GRID_COLS + c] = 1'b0;
         frontier.delete();
         cur = it.cell_row * GRID_COLS + it.cell_col;
         reached[cur] = 1'b1;
         steps[cur] = '0;
         frontier.push_back(cur);
         while (frontier.size() != 0) begin
            cur = frontier.pop_front();
            r = cur / GRID_COLS;
            c = cur % GRID_COLS;
            nd = (steps[cur] == '1) ? steps[cur] : steps[cur] + 1'b1;
            // up, left, right, down
            for (j = 0; j < 4; j++) begin
               nr = r + ((j == 0) ? -1 : (j == 3) ? 1 : 0);
               nc = c + ((j == 1) ? -1 : (j == 2) ? 1 : 0);
               if (nr >= 0 && nc >= 0 && nr < rows_n && nc < cols_n) begin
                  idx = nr * GRID_COLS + nc;
                  if (!obstacle[idx] && !reached[idx]) begin
                     reached[idx] = 1'b1;
                     steps[idx] = nd;
                     frontier.push_back(idx);
                  end
               end
            end
         end
         if (it.dest_row < rows_n && it.dest_col < cols_n) begin
            idx = it.dest_row * GRID_COLS + it.dest_col;
            if (reached[idx]) begin
               res.reachable = 1'b1;
               res.distance = steps[idx];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rows_setting = DIM_RESET;
         cols_setting = DIM_RESET;
         foreach (obstacle[i]) obstacle[i] = 1'b0;
         expected_paths.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[REG_BIT] == REG_COLS)
               cols_setting = csr_pwdata[DIM_W-1:0];
            else
               rows_setting = csr_pwdata[DIM_W-1:0];
         end
         // retire results before taking new items: a result never stems from
         // an item accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_paths.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("result %0d: unexpected, distance %0d reachable %0b",
                           result_count, rsp_data.distance, rsp_data.reachable);
            end else begin
               want = expected_paths.pop_front();
               if (rsp_data.distance !== want.distance ||
                   rsp_data.reachable !== want.reachable) begin
                  errors++;
                  if (errors <= REPORT_MAX)
                     $display("result %0d: expected distance %0d reachable %0b, got %0d %0b",
                              result_count, want.distance, want.reachable,
                              rsp_data.distance, rsp_data.reachable);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.kind)
               KIND_CLEAR: foreach (obstacle[i]) obstacle[i] = 1'b0;
               KIND_BLOCK: obstacle[req_data.cell_row * GRID_COLS + req_data.cell_col] = 1'b1;
               KIND_QUERY: expected_paths.push_back(flood_distance(req_data));
               default: ;
            endcase
         end
      end
      outstanding <= expected_paths.size();
      mismatches  <= errors;
   end

endmodule

/* tb/grid_bfs_shortest_path_tb.sv */
// Testbench top of the grid path finder: stimulus, register writes and the verdict.
module grid_bfs_shortest_path_tb;
   import gbsp_pkg::*;

   // A clear or an epoch wipe sweeps the whole cell memory with nothing accepted; the
   // longest flood used here covers 400 cells. Allow plenty more.
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 80;
   localparam int IDLE_PCT       = 6;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   bit steady_send = 1'b0;
   bit steady_take = 1'b0;
   int rows_in_use = DEF_MAX_ROWS;
   int cols_in_use = DEF_MAX_COLS;

   grid_bfs_shortest_path uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   grid_path_checker u_path_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: stall now and then, except through the steady stretch.
   always @(posedge clock) begin
      if (reset || steady_take)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Watchdog: count cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type item_of(input logic [1:0] kind, input int r, input int c,
                                       input int dr, input int dc);
      req_type it;
      it.kind     = kind;
      it.cell_row = 8'(r);
      it.cell_col = 8'(c);
      it.dest_row = 8'(dr);
      it.dest_col = 8'(dc);
      return it;
   endfunction

   // Mostly well-formed items inside the grid in use; a share of blocks and
   // queries reach anywhere in the 8-bit field range, and a few are ignored.
   function automatic req_type random_item(input int block_share);
      int roll, sel, reach_r, reach_c;
      req_type it;
      roll = $urandom_range(0, 99);
      it = item_of(KIND_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      if (roll < block_share) begin
         it.kind = KIND_BLOCK;
         sel = $urandom_range(0, 9);
         reach_r = (2 * rows_in_use + 2 > 255) ? 255 : 2 * rows_in_use + 2;
         reach_c = (2 * cols_in_use + 2 > 255) ? 255 : 2 * cols_in_use + 2;
         if (sel < 8) begin
            it.cell_row = 8'($urandom_range(0, rows_in_use - 1));
            it.cell_col = 8'($urandom_range(0, cols_in_use - 1));
         end else if (sel == 8) begin
            // just beyond the grid: matters once the grid grows
            it.cell_row = 8'($urandom_range(0, reach_r));
            it.cell_col = 8'($urandom_range(0, reach_c));
         end
      end else if (roll < 92) begin
         if ($urandom_range(0, 9) != 0) begin
            it.cell_row = 8'($urandom_range(0, rows_in_use - 1));
            it.cell_col = 8'($urandom_range(0, cols_in_use - 1));
         end
         if ($urandom_range(0, 6) != 0) begin
            it.dest_row = 8'($urandom_range(0, rows_in_use - 1));
            it.dest_col = 8'($urandom_range(0, cols_in_use - 1));
         end
      end else if (roll < 96) begin
         it.kind = KIND_UNUSED;
      end
      return it;
   endfunction

   // Offer one transaction, with the odd gap, and hold it until accepted.
   task automatic send_item(input req_type it);
      while (!steady_send && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         req_data  <= item_of(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Bring the block to rest before a register write.
   task automatic settle();
      hold_until_drained();
      repeat (16) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; junk in the upper data bits is ignored.
   task automatic csr_write(input logic idx, input int unsigned value);
      logic [CSR_DW-1:0] junk;
      int dim;
      junk = $urandom();
      dim = (value[DIM_W-1:0] == 0) ? 1 :
            (value[DIM_W-1:0] > DEF_MAX_ROWS) ? DEF_MAX_ROWS : value[DIM_W-1:0];
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {junk[CSR_DW-1:DIM_W], value[DIM_W-1:0]};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_ROWS)
         rows_in_use = dim;
      else
         cols_in_use = dim;
   endtask

   initial begin
      int phase, n, block_share, rows_w, cols_w;
      req_type it;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: full 256 x 256 grid at reset, start walled into the corner.
      send_item(item_of(KIND_BLOCK, 0, 1, 0, 0));
      send_item(item_of(KIND_BLOCK, 1, 0, 0, 0));
      send_item(item_of(KIND_BLOCK, 255, 255, 255, 255));
      send_item(item_of(KIND_QUERY, 0, 0, 0, 0));       // destination is the start
      send_item(item_of(KIND_QUERY, 0, 0, 255, 255));   // walled off
      send_item(item_of(KIND_UNUSED, 255, 255, 255, 255));

      settle();
      csr_write(REG_ROWS, 4);
      csr_write(REG_COLS, 5);
      send_item(item_of(KIND_BLOCK, 2, 2, 0, 0));
      send_item(item_of(KIND_QUERY, 2, 2, 3, 4));       // blocked start still floods
      send_item(item_of(KIND_QUERY, 2, 2, 0, 0));       // corner still walled
      send_item(item_of(KIND_QUERY, 4, 0, 0, 0));       // start below the grid
      send_item(item_of(KIND_QUERY, 0, 4, 0, 5));       // destination right of the grid
      send_item(item_of(KIND_CLEAR, 0, 0, 0, 0));
      send_item(item_of(KIND_QUERY, 2, 2, 0, 0));
      send_item(item_of(KIND_QUERY, 3, 4, 0, 0));

      // Zero dimensions act as a single cell.
      settle();
      csr_write(REG_ROWS, 0);
      csr_write(REG_COLS, 0);
      send_item(item_of(KIND_QUERY, 0, 0, 0, 0));
      send_item(item_of(KIND_QUERY, 0, 0, 1, 0));
      send_item(item_of(KIND_QUERY, 0, 1, 0, 0));

      // Oversized row count clamps to the storage height: one long column.
      settle();
      csr_write(REG_ROWS, 511);
      csr_write(REG_COLS, 1);
      send_item(item_of(KIND_QUERY, 0, 0, 255, 0));
      send_item(item_of(KIND_BLOCK, 200, 0, 0, 0));
      send_item(item_of(KIND_QUERY, 255, 0, 201, 0));
      send_item(item_of(KIND_QUERY, 255, 0, 0, 0));

      // One long row at the full width.
      settle();
      csr_write(REG_ROWS, 1);
      csr_write(REG_COLS, 256);
      send_item(item_of(KIND_QUERY, 0, 255, 0, 0));
      send_item(item_of(KIND_QUERY, 0, 128, 0, 255));

      // Random phases: mostly small grids, since the flood visits every reached cell in
      // turn; a clear costs a full sweep, so only some phases clear.
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            2: begin
               rows_w = $urandom_range(257, 511);
               cols_w = 1;
            end
            5: begin
               rows_w = 1;
               cols_w = 256;
            end
            6: begin
               rows_w = 0;
               cols_w = $urandom_range(0, 12);
            end
            7: begin
               rows_w = $urandom_range(10, 20);
               cols_w = $urandom_range(10, 20);
            end
            default: begin
               rows_w = $urandom_range(1, 12);
               cols_w = $urandom_range(1, 12);
            end
         endcase
         csr_write(REG_ROWS, rows_w);
         csr_write(REG_COLS, cols_w);
         block_share = $urandom_range(15, 45);
         // one stretch with no idling on either side
         steady_send = (phase == 3);
         steady_take = (phase == 3);
         if ($urandom_range(0, 1) == 1)
            send_item(item_of(KIND_CLEAR, 0, 0, 0, 0));
         n = 0;
         while (n < PHASE_ITEMS) begin
            // now and then hold off until the result side is empty
            if ($urandom_range(0, 29) == 0)
               hold_until_drained();
            it = random_item(block_share);
            send_item(it);
            if (it.kind != KIND_UNUSED)
               n++;
         end
         // close on a query so the phase ends with a result
         send_item(item_of(KIND_QUERY, 0, 0, rows_in_use - 1, cols_in_use - 1));
      end
      steady_send = 1'b0;
      steady_take = 1'b0;

      hold_until_drained();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* grid_bfs_shortest_path.f */
rtl/gbsp_pkg.sv
rtl/gbsp_engine.sv
rtl/grid_bfs_shortest_path.sv
rtl/gbsp_checker.sv
tb/grid_path_checker.sv
tb/grid_bfs_shortest_path_tb.sv
